// ===== sv/dsfp_pkg.sv =====
`timescale 1ns / 1ps

package dsfp_pkg;

   // Field widths
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned TENTH_W = 16;
   localparam int unsigned TICK_W  = 32;
   localparam int unsigned STAT_W  = 2;
   localparam int unsigned CSR_W   = 32;
   localparam int unsigned CSR_IDX_W = 2;

   // Frame marker bytes
   localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'hAA;
   localparam logic [BYTE_W-1:0] HDR_SECOND = 8'hC0;
   localparam logic [BYTE_W-1:0] TAIL_BYTE  = 8'hAB;

   // Result status codes
   localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_CHECKSUM = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_RANGE    = 2'd2;
   localparam logic [STAT_W-1:0] STATUS_TIMEOUT  = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_LIMIT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FINE_CEILING   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COARSE_CEILING = 2'd2;

   // Register reset values
   localparam logic [TICK_W-1:0]  TIMEOUT_LIMIT_RST  = 32'd1500000;
   localparam logic [TENTH_W-1:0] FINE_CEILING_RST   = 16'd10000;
   localparam logic [TENTH_W-1:0] COARSE_CEILING_RST = 16'd20000;

   typedef struct packed {
      logic              action;
      logic [BYTE_W-1:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic [TICK_W-1:0]  timeout_limit;
      logic [TENTH_W-1:0] fine_ceiling;
      logic [TENTH_W-1:0] coarse_ceiling;
   } cfg_type;

endpackage

// ===== sv/dsfp_if.sv =====
`timescale 1ns / 1ps

// Request channel: received bytes and ticks
interface dsfp_req_if import dsfp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              action;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, action, rx_byte, input ready);
   modport sink   (input valid, action, rx_byte, output ready);
endinterface

// Result channel
interface dsfp_rsp_if import dsfp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [STAT_W-1:0]  status;
   logic [TENTH_W-1:0] fine_tenths;
   logic [TENTH_W-1:0] coarse_tenths;
   logic [TICK_W-1:0]  elapsed_ticks;

   modport source (output valid, status, fine_tenths, coarse_tenths, elapsed_ticks,
                   input ready);
   modport sink   (input valid, status, fine_tenths, coarse_tenths, elapsed_ticks,
                   output ready);
endinterface

// ===== sv/dust_sensor_frame_parser_unit.sv =====
`timescale 1ns / 1ps
// A taken request is held first in the input stage register, and its result then in the result register on rsp_bus.
// Throughput: one request per cycle while results are taken; a held result stalls the input.
// A request that completes no frame and no timeout gives no result.
// Reset is synchronous and active high: parser hunts for a header, tick count is zero,
// and the registers return to limit 1500000 and ceilings 10000 and 20000.

module dust_sensor_frame_parser_unit import dsfp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   dsfp_req_if.sink             req_bus,
   dsfp_rsp_if.source           rsp_bus,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   cfg_type  cfg;
   logic     item_valid;
   item_type item;
   logic     item_take;

   dsfp_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   dsfp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   dsfp_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .cfg        (cfg),
      .rsp_bus    (rsp_bus)
   );

endmodule

// ===== sv/dsfp_csr.sv =====
`timescale 1ns / 1ps

module dsfp_csr import dsfp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;

   // Register file; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_limit  <= TIMEOUT_LIMIT_RST;
         cfg_ff.fine_ceiling   <= FINE_CEILING_RST;
         cfg_ff.coarse_ceiling <= COARSE_CEILING_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_TIMEOUT_LIMIT:  cfg_ff.timeout_limit  <= csr_wdata[TICK_W-1:0];
            CSR_FINE_CEILING:   cfg_ff.fine_ceiling   <= csr_wdata[TENTH_W-1:0];
            CSR_COARSE_CEILING: cfg_ff.coarse_ceiling <= csr_wdata[TENTH_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/dsfp_in_stage.sv =====
`timescale 1ns / 1ps

module dsfp_in_stage import dsfp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   dsfp_req_if.sink   req_bus,
   output logic       item_valid,
   output item_type   item,
   input  logic       item_take
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     accept;

   // Room when no request is held or the held request moves on this cycle
   assign req_bus.ready = !valid_ff || item_take;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.action  <= req_bus.action;
         item_ff.rx_byte <= req_bus.rx_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== sv/dsfp_core.sv =====
`timescale 1ns / 1ps

module dsfp_core import dsfp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  item_type   item,
   output logic       item_take,
   input  cfg_type    cfg,
   dsfp_rsp_if.source rsp_bus
);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_GOT_AA,
      PH_PAYLOAD,
      PH_TAIL
   } phase_type;

   localparam logic [3:0]        POS_FIRST = 4'd2;
   localparam logic [3:0]        POS_LAST_DATA = 4'd7;
   localparam logic [3:0]        POS_LAST_WORD = 4'd5;
   localparam logic [3:0]        POS_TAIL = 4'd9;
   localparam logic [TICK_W-1:0] TICK_MAX = '1;

   phase_type          phase_ff, phase_in;
   logic [3:0]         pos_ff, pos_in;
   logic [BYTE_W-1:0]  sum_ff, sum_in;
   logic [BYTE_W-1:0]  pay_ff [4];
   logic [BYTE_W-1:0]  pay_in [4];
   logic [BYTE_W-1:0]  rsum_ff, rsum_in;
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]  status_ff, status_in;
   logic [TENTH_W-1:0] fine_ff, fine_in;
   logic [TENTH_W-1:0] coarse_ff, coarse_in;
   logic [TICK_W-1:0]  elapsed_ff, elapsed_in;

   logic               emit;
   logic [TICK_W-1:0]  tick_inc;
   logic [TENTH_W-1:0] fine_word;
   logic [TENTH_W-1:0] coarse_word;
   logic [BYTE_W-1:0]  b;
   logic [1:0]         slot;

   // A held request moves when the result register is free or draining
   assign item_take = item_valid && (!rsp_valid_ff || rsp_bus.ready);

   assign tick_inc    = (tick_ff == TICK_MAX) ? tick_ff : tick_ff + 1'b1;
   assign fine_word   = {pay_ff[1], pay_ff[0]};
   assign coarse_word = {pay_ff[3], pay_ff[2]};
   assign b           = item.rx_byte;
   assign slot        = pos_ff[1:0] - 2'd2;

   // Frame parsing and tick counting
   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      sum_in     = sum_ff;
      pay_in     = pay_ff;
      rsum_in    = rsum_ff;
      tick_in    = tick_ff;
      emit       = 1'b0;
      status_in  = STATUS_OK;
      fine_in    = '0;
      coarse_in  = '0;
      elapsed_in = tick_ff;

      if (item.action) begin
         tick_in = tick_inc;
         if (tick_inc > cfg.timeout_limit) begin
            emit       = 1'b1;
            status_in  = STATUS_TIMEOUT;
            elapsed_in = tick_inc;
         end
      end else begin
         case (phase_ff)
            PH_GOT_AA: begin
               if (b == HDR_SECOND) begin
                  phase_in = PH_PAYLOAD;
                  pos_in   = POS_FIRST;
                  sum_in   = '0;
               end else if (b != HDR_FIRST) begin
                  phase_in = PH_HUNT;
                  pos_in   = POS_FIRST;
                  sum_in   = '0;
               end
            end
            PH_PAYLOAD: begin
               if (pos_ff <= POS_LAST_DATA) begin
                  if (pos_ff <= POS_LAST_WORD) begin
                     pay_in[slot] = b;
                  end
                  sum_in = sum_ff + b;
                  pos_in = pos_ff + 4'd1;
               end else begin
                  rsum_in  = b;
                  phase_in = PH_TAIL;
                  pos_in   = POS_TAIL;
               end
            end
            PH_TAIL: begin
               if (b == TAIL_BYTE) begin
                  emit = 1'b1;
                  if (sum_ff != rsum_ff) begin
                     status_in = STATUS_CHECKSUM;
                  end else begin
                     fine_in   = fine_word;
                     coarse_in = coarse_word;
                     if (fine_word > cfg.fine_ceiling ||
                         coarse_word > cfg.coarse_ceiling) begin
                        status_in = STATUS_RANGE;
                     end
                  end
               end else begin
                  phase_in = (b == HDR_FIRST) ? PH_GOT_AA : PH_HUNT;
                  pos_in   = POS_FIRST;
                  sum_in   = '0;
               end
            end
            default: begin
               phase_in = (b == HDR_FIRST) ? PH_GOT_AA : PH_HUNT;
               pos_in   = POS_FIRST;
               sum_in   = '0;
            end
         endcase
      end

      // Any result clears the tick count and restarts the hunt
      if (emit) begin
         tick_in  = '0;
         phase_in = PH_HUNT;
         pos_in   = POS_FIRST;
         sum_in   = '0;
      end
   end

   // Result register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (item_take) begin
         rsp_valid_in = emit;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Parser state, frame data and result register; data needs no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         pos_ff       <= POS_FIRST;
         sum_ff       <= '0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (item_take) begin
            phase_ff <= phase_in;
            pos_ff   <= pos_in;
            sum_ff   <= sum_in;
            tick_ff  <= tick_in;
         end
      end
      if (item_take) begin
         pay_ff  <= pay_in;
         rsum_ff <= rsum_in;
      end
      if (item_take && emit) begin
         status_ff  <= status_in;
         fine_ff    <= fine_in;
         coarse_ff  <= coarse_in;
         elapsed_ff <= elapsed_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = status_ff;
   assign rsp_bus.fine_tenths   = fine_ff;
   assign rsp_bus.coarse_tenths = coarse_ff;
   assign rsp_bus.elapsed_ticks = elapsed_ff;

endmodule

// ===== sv/dsfp_checker.sv =====
`timescale 1ns / 1ps

module dsfp_checker import dsfp_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [STAT_W-1:0]  rsp_status,
   input logic [TENTH_W-1:0] rsp_fine,
   input logic [TENTH_W-1:0] rsp_coarse
);

   // Results stay offered until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // Timeout carries no reading
   a_timeout_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_TIMEOUT |-> rsp_fine == '0 && rsp_coarse == '0)
      else $error("timeout result with nonzero reading");

   // Checksum error carries no reading
   a_cksum_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_CHECKSUM |-> rsp_fine == '0 && rsp_coarse == '0)
      else $error("checksum error result with nonzero reading");

   // Nothing offered just after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind dust_sensor_frame_parser_unit dsfp_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_status (rsp_bus.status),
   .rsp_fine   (rsp_bus.fine_tenths),
   .rsp_coarse (rsp_bus.coarse_tenths)
);
